// ===== rtl/core/txuvw_pkg.sv =====
// Shared types and constants for the texture coordinate transform and wrap unit.
// Holds field widths, register and wrap mode codes, and the configuration struct.
// No dependencies.
package txuvw_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int COORD_W    = 24;  // coordinate ports, signed
  localparam int PAIR_W     = 16;  // one half of a scale/rotation/tiling register
  localparam int OFFS_W     = 24;  // one half of the translation register
  localparam int SCALE_FRAC = 8;   // Q8.8 scale and tiling
  localparam int ROT_FRAC   = 14;  // Q2.14 cosine and sine
  localparam int XF_W       = 45;  // transformed coordinate, before wrap
  localparam int MODE_W     = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILING      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = 3'd4;

  // wrap modes
  localparam logic [MODE_W-1:0] WRAP_REPEAT = 3'd0;
  localparam logic [MODE_W-1:0] WRAP_MIRROR = 3'd1;
  localparam logic [MODE_W-1:0] WRAP_CLAMP  = 3'd2;
  localparam logic [MODE_W-1:0] WRAP_PLANAR = 3'd3;
  localparam logic [MODE_W-1:0] WRAP_CUBIC  = 3'd4;

  typedef struct packed {
    logic [PAIR_W-1:0] scale_u;
    logic [PAIR_W-1:0] scale_v;
    logic [PAIR_W-1:0] rot_cos;
    logic [PAIR_W-1:0] rot_sin;
    logic [OFFS_W-1:0] offs_u;
    logic [OFFS_W-1:0] offs_v;
    logic [PAIR_W-1:0] tile_u;
    logic [PAIR_W-1:0] tile_v;
    logic [MODE_W-1:0] wrap_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    scale_u:   16'h0100,
    scale_v:   16'h0100,
    rot_cos:   16'h4000,
    rot_sin:   16'h0000,
    offs_u:    24'h000000,
    offs_v:    24'h000000,
    tile_u:    16'h0100,
    tile_v:    16'h0100,
    wrap_mode: WRAP_REPEAT
  };

endpackage

// ===== rtl/core/txuvw_xform.sv =====
// Affine part of the coordinate unit: center, scale, rotate, recenter, translate, tile.
// Four register stages; stages 1, 2 and 4 multiply, stage 3 adds. Depends on txuvw_pkg.
module txuvw_xform #(
  parameter int FRAC = txuvw_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [txuvw_pkg::COORD_W-1:0] u_in,
  input  logic signed [txuvw_pkg::COORD_W-1:0] v_in,
  input  txuvw_pkg::cfg_t                     cfg,
  output logic                                out_valid,
  output logic signed [txuvw_pkg::XF_W-1:0]    t_u,
  output logic signed [txuvw_pkg::XF_W-1:0]    t_v,
  output logic signed [txuvw_pkg::COORD_W-1:0] raw_u,
  output logic signed [txuvw_pkg::COORD_W-1:0] raw_v
);
  import txuvw_pkg::*;

  localparam int D_W  = COORD_W + 1;
  localparam int P1_W = D_W + PAIR_W;
  localparam int Q1_W = P1_W - SCALE_FRAC;
  localparam int P2_W = Q1_W + PAIR_W;
  localparam int R2_W = P2_W + 1;
  localparam int Q2_W = R2_W - ROT_FRAC;
  localparam int W_W  = Q2_W + 1;
  localparam int P3_W = W_W + PAIR_W;

  localparam logic signed [D_W-1:0] HALF = D_W'(1) << (FRAC - 1);

  logic signed [PAIR_W-1:0] scale_u, scale_v, rot_cos, rot_sin, tile_u, tile_v;
  logic signed [OFFS_W-1:0] offs_u, offs_v;

  assign scale_u = cfg.scale_u;
  assign scale_v = cfg.scale_v;
  assign rot_cos = cfg.rot_cos;
  assign rot_sin = cfg.rot_sin;
  assign offs_u  = cfg.offs_u;
  assign offs_v  = cfg.offs_v;
  assign tile_u  = cfg.tile_u;
  assign tile_v  = cfg.tile_v;

  // stage 1: (x - 1/2) * scale
  logic signed [D_W-1:0]  du, dv;
  logic signed [P1_W-1:0] p1u_c, p1v_c;
  logic                   v1;
  logic signed [P1_W-1:0] p1u, p1v;
  logic signed [COORD_W-1:0] raw1u, raw1v;

  assign du    = D_W'(u_in) - HALF;
  assign dv    = D_W'(v_in) - HALF;
  assign p1u_c = du * scale_u;
  assign p1v_c = dv * scale_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    p1u   <= p1u_c;
    p1v   <= p1v_c;
    raw1u <= u_in;
    raw1v <= v_in;
  end

  // stage 2: rotation products
  logic signed [Q1_W-1:0] q1u, q1v;
  logic                   v2;
  logic signed [P2_W-1:0] m_uc, m_vs, m_us, m_vc;
  logic signed [COORD_W-1:0] raw2u, raw2v;

  assign q1u = p1u[P1_W-1:SCALE_FRAC];
  assign q1v = p1v[P1_W-1:SCALE_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    m_uc  <= q1u * rot_cos;
    m_vs  <= q1v * rot_sin;
    m_us  <= q1u * rot_sin;
    m_vc  <= q1v * rot_cos;
    raw2u <= raw1u;
    raw2v <= raw1v;
  end

  // stage 3: combine, shift, recenter and translate
  logic signed [R2_W-1:0] r2u, r2v;
  logic signed [Q2_W-1:0] q2u, q2v;
  logic                   v3;
  logic signed [W_W-1:0]  wu, wv;
  logic signed [COORD_W-1:0] raw3u, raw3v;

  assign r2u = m_uc - m_vs;
  assign r2v = m_us + m_vc;
  assign q2u = r2u[R2_W-1:ROT_FRAC];
  assign q2v = r2v[R2_W-1:ROT_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    wu    <= q2u + HALF + offs_u;
    wv    <= q2v + HALF + offs_v;
    raw3u <= raw2u;
    raw3v <= raw2v;
  end

  // stage 4: tiling
  logic signed [P3_W-1:0] p3u, p3v;

  assign p3u = wu * tile_u;
  assign p3v = wv * tile_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3;
    end
    t_u   <= p3u[P3_W-1:SCALE_FRAC];
    t_v   <= p3v[P3_W-1:SCALE_FRAC];
    raw_u <= raw3u;
    raw_v <= raw3v;
  end

endmodule

// ===== rtl/core/txuvw_wrap.sv =====
// Wrap part of the coordinate unit: repeat, mirror, clamp, planar and cubic face remap.
// Seven register stages, the last one drives the result ports. Depends on txuvw_pkg.
module txuvw_wrap #(
  parameter int FRAC = txuvw_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [txuvw_pkg::XF_W-1:0]    t_u,
  input  logic signed [txuvw_pkg::XF_W-1:0]    t_v,
  input  logic signed [txuvw_pkg::COORD_W-1:0] raw_u,
  input  logic signed [txuvw_pkg::COORD_W-1:0] raw_v,
  input  logic [txuvw_pkg::MODE_W-1:0]         mode,
  output logic                                done,
  output logic signed [txuvw_pkg::COORD_W-1:0] u_out,
  output logic signed [txuvw_pkg::COORD_W-1:0] v_out
);
  import txuvw_pkg::*;

  localparam int S_W      = XF_W + 2;        // holds 3*t
  localparam int SMAG_W   = S_W - 1;
  localparam int TRM_W    = SMAG_W - FRAC;   // integer part magnitude
  localparam int TR_W     = TRM_W + 1;
  localparam int FACE_W   = TRM_W + 4;
  localparam int FMAG_W   = FACE_W - 1;
  localparam int L_W      = FRAC + 1;
  localparam int C_W      = FRAC + 2;
  localparam int SAT_IN_W = 48;
  localparam int FOLD_W   = 48;
  localparam int P_W      = 18;
  localparam int F10_W    = 10;

  localparam logic signed [S_W-1:0] ONE   = S_W'(1) << FRAC;
  localparam logic signed [S_W-1:0] TWO   = ONE <<< 1;
  localparam logic signed [S_W-1:0] MASK1 = ONE - S_W'(1);
  localparam logic signed [S_W-1:0] MASK2 = TWO - S_W'(1);
  localparam logic signed [C_W-1:0] ONE_C = C_W'(1) << FRAC;

  localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);

  localparam logic [2:0] FACE_0 = 3'd0;
  localparam logic [2:0] FACE_1 = 3'd1;
  localparam logic [2:0] FACE_2 = 3'd2;
  localparam logic [2:0] FACE_3 = 3'd3;
  localparam logic [2:0] FACE_4 = 3'd4;
  localparam logic [2:0] FACE_5 = 3'd5;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [SAT_IN_W-1:0] x);
    logic signed [SAT_IN_W-1:0] r;
    r = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
    return r[COORD_W-1:0];
  endfunction

  function automatic logic signed [S_W-1:0] pick_pre(input logic [MODE_W-1:0] md,
                                                     input logic signed [S_W-1:0] tw,
                                                     input logic signed [COORD_W-1:0] raw);
    logic signed [S_W-1:0] m2;
    logic signed [S_W-1:0] r;
    m2 = tw & MASK2;
    case (md)
      WRAP_REPEAT: r = tw & MASK1;
      WRAP_MIRROR: r = (m2 > ONE) ? (TWO - m2) : m2;
      WRAP_CLAMP:  r = (tw < 0) ? '0 : ((tw > ONE) ? ONE : tw);
      WRAP_PLANAR: r = S_W'(raw);
      default:     r = tw;  // cubic falls back to t, unknown modes pass t
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mod3(input logic [3:0] y);
    logic [3:0] r;
    if (y >= 4'd12) begin
      r = y - 4'd12;
    end else if (y >= 4'd9) begin
      r = y - 4'd9;
    end else if (y >= 4'd6) begin
      r = y - 4'd6;
    end else if (y >= 4'd3) begin
      r = y - 4'd3;
    end else begin
      r = y;
    end
    return r[1:0];
  endfunction

  // residue mod 6 from residues mod 2 and mod 3
  function automatic logic [2:0] mod6(input logic b0, input logic [1:0] m3);
    logic [2:0] r;
    case ({b0, m3})
      3'b000:  r = FACE_0;
      3'b101:  r = FACE_1;
      3'b010:  r = FACE_2;
      3'b100:  r = FACE_3;
      3'b001:  r = FACE_4;
      3'b110:  r = FACE_5;
      default: r = FACE_0;
    endcase
    return r;
  endfunction

  // stage 5: non-cubic result and s = 3t
  logic signed [S_W-1:0] tw_u, tw_v;
  logic                  v5, cub5;
  logic signed [S_W-1:0] s5_u, s5_v, pre5_u, pre5_v;

  assign tw_u = S_W'(t_u);
  assign tw_v = S_W'(t_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= in_valid;
    end
    cub5   <= (mode == WRAP_CUBIC);
    s5_u   <= (tw_u <<< 1) + tw_u;
    s5_v   <= (tw_v <<< 1) + tw_v;
    pre5_u <= pick_pre(mode, tw_u, raw_u);
    pre5_v <= pick_pre(mode, tw_v, raw_v);
  end

  // stage 6: magnitude of s, saturate the fallback
  logic signed [S_W-1:0] sa_u, sa_v;
  logic                  v6, cub6, neg6_u, neg6_v;
  logic [SMAG_W-1:0]     mag6_u, mag6_v;
  logic signed [COORD_W-1:0] pre6_u, pre6_v;

  assign sa_u = s5_u[S_W-1] ? -s5_u : s5_u;
  assign sa_v = s5_v[S_W-1] ? -s5_v : s5_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    cub6   <= cub5;
    neg6_u <= s5_u[S_W-1];
    neg6_v <= s5_v[S_W-1];
    mag6_u <= sa_u[SMAG_W-1:0];
    mag6_v <= sa_v[SMAG_W-1:0];
    pre6_u <= sat(SAT_IN_W'(pre5_u));
    pre6_v <= sat(SAT_IN_W'(pre5_v));
  end

  // stage 7: truncated integer part and signed fraction
  logic signed [TR_W-1:0] tre_u, tre_v;
  logic signed [L_W-1:0]  le_u, le_v;
  logic                   v7, cub7;
  logic signed [TR_W-1:0] tr7_u, tr7_v;
  logic signed [L_W-1:0]  l7_u, l7_v;
  logic signed [COORD_W-1:0] pre7_u, pre7_v;

  assign tre_u = {1'b0, mag6_u[SMAG_W-1:FRAC]};
  assign tre_v = {1'b0, mag6_v[SMAG_W-1:FRAC]};
  assign le_u  = {1'b0, mag6_u[FRAC-1:0]};
  assign le_v  = {1'b0, mag6_v[FRAC-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    cub7   <= cub6;
    tr7_u  <= neg6_u ? -tre_u : tre_u;
    tr7_v  <= neg6_v ? -tre_v : tre_v;
    l7_u   <= neg6_u ? -le_u : le_u;
    l7_v   <= neg6_v ? -le_v : le_v;
    pre7_u <= pre6_u;
    pre7_v <= pre6_v;
  end

  // stage 8: face number and local coordinate candidates
  logic signed [FACE_W-1:0] trv_e;
  logic                     v8, cub8;
  logic signed [FACE_W-1:0] face8;
  logic signed [C_W-1:0]    c8_lu, c8_lv, c8_olu, c8_olv;
  logic signed [COORD_W-1:0] pre8_u, pre8_v;

  assign trv_e = FACE_W'(tr7_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    cub8   <= cub7;
    face8  <= FACE_W'(tr7_u) + (trv_e <<< 1) + trv_e;
    c8_lu  <= C_W'(l7_u);
    c8_lv  <= C_W'(l7_v);
    c8_olu <= ONE_C - C_W'(l7_u);
    c8_olv <= ONE_C - C_W'(l7_v);
    pre8_u <= pre7_u;
    pre8_v <= pre7_v;
  end

  // stage 9: face magnitude, saturate candidates
  logic signed [FACE_W-1:0] fabs;
  logic                     v9, cub9, fneg9;
  logic [FMAG_W-1:0]        fmag9;
  logic signed [COORD_W-1:0] c9_lu, c9_lv, c9_olu, c9_olv, pre9_u, pre9_v;

  assign fabs = face8[FACE_W-1] ? -face8 : face8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    cub9   <= cub8;
    fneg9  <= face8[FACE_W-1];
    fmag9  <= fabs[FMAG_W-1:0];
    c9_lu  <= sat(SAT_IN_W'(c8_lu));
    c9_lv  <= sat(SAT_IN_W'(c8_lv));
    c9_olu <= sat(SAT_IN_W'(c8_olu));
    c9_olv <= sat(SAT_IN_W'(c8_olv));
    pre9_u <= pre8_u;
    pre9_v <= pre8_v;
  end

  // stage 10: fold the magnitude for mod 3 (2^16 and 2^8 are 1 mod 3)
  logic [FOLD_W-1:0] fm;
  logic [P_W-1:0]    p16;
  logic              v10, cub10, fneg10, b0_10;
  logic [F10_W-1:0]  f10;
  logic signed [COORD_W-1:0] c10_lu, c10_lv, c10_olu, c10_olv, pre10_u, pre10_v;

  assign fm  = FOLD_W'(fmag9);
  assign p16 = P_W'(fm[15:0]) + P_W'(fm[31:16]) + P_W'(fm[47:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    cub10   <= cub9;
    fneg10  <= fneg9;
    b0_10   <= fmag9[0];
    f10     <= F10_W'(p16[7:0]) + F10_W'(p16[15:8]) + F10_W'(p16[17:16]);
    c10_lu  <= c9_lu;
    c10_lv  <= c9_lv;
    c10_olu <= c9_olu;
    c10_olv <= c9_olv;
    pre10_u <= pre9_u;
    pre10_v <= pre9_v;
  end

  // stage 11: face select, result register
  logic [3:0] dsum;
  logic [2:0] face;
  logic       face_hit;
  logic signed [COORD_W-1:0] sel_u, sel_v;

  assign dsum = 4'(f10[1:0]) + 4'(f10[3:2]) + 4'(f10[5:4]) + 4'(f10[7:6]) + 4'(f10[9:8]);
  assign face = mod6(b0_10, mod3(dsum));
  // a negative face with a nonzero remainder matches no face
  assign face_hit = cub10 && (!fneg10 || face == FACE_0);

  always_comb begin
    sel_u = pre10_u;
    sel_v = pre10_v;
    if (face_hit) begin
      case (face)
        FACE_0: begin sel_u = c10_lu;  sel_v = c10_lv;  end
        FACE_1: begin sel_u = c10_lv;  sel_v = c10_olu; end
        FACE_2: begin sel_u = c10_olu; sel_v = c10_lv;  end
        FACE_3: begin sel_u = c10_olv; sel_v = c10_olu; end
        FACE_4: begin sel_u = c10_lu;  sel_v = c10_olv; end
        default: begin sel_u = c10_lu; sel_v = c10_lv;  end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v10;
    end
    u_out <= sel_u;
    v_out <= sel_v;
  end

endmodule

// ===== rtl/core/texture_uv_transform_wrap_top.sv =====
// Texture coordinate transform and wrap, top level.
// Throughput: one item per cycle outside reset; 4 transform stages plus 7 wrap stages, fully pipelined.
// busy is high only while rst is high; the receiver cannot stall, results leave on done.
// Synchronous reset clears the pipeline valids and loads the register defaults.
// Depends on txuvw_pkg, txuvw_xform and txuvw_wrap.
module texture_uv_transform_wrap_top #(
  parameter int COORD_FRAC_BITS = txuvw_pkg::COORD_FRAC_BITS_DEF  // 8 to 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // item channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [txuvw_pkg::COORD_W-1:0]    u_in,
  input  logic signed [txuvw_pkg::COORD_W-1:0]    v_in,
  // result channel
  output logic                                   done,
  output logic signed [txuvw_pkg::COORD_W-1:0]    u_out,
  output logic signed [txuvw_pkg::COORD_W-1:0]    v_out,
  // register write port
  input  logic                                   cfg_we,
  input  logic [txuvw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [txuvw_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import txuvw_pkg::*;

  cfg_t cfg;
  logic take;

  // Registers: write them only while the pipeline is empty, which the block does not
  // enforce; every stage reads them directly instead of carrying a copy with each item.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE: begin
          cfg.scale_u <= cfg_wdata[31:16];
          cfg.scale_v <= cfg_wdata[15:0];
        end
        REG_ROTATION: begin
          cfg.rot_cos <= cfg_wdata[31:16];
          cfg.rot_sin <= cfg_wdata[15:0];
        end
        REG_TRANSLATION: begin
          cfg.offs_u <= cfg_wdata[47:24];
          cfg.offs_v <= cfg_wdata[23:0];
        end
        REG_TILING: begin
          cfg.tile_u <= cfg_wdata[31:16];
          cfg.tile_v <= cfg_wdata[15:0];
        end
        REG_WRAP_MODE: begin
          cfg.wrap_mode <= cfg_wdata[MODE_W-1:0];
        end
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // The pipeline takes an item every cycle; it only refuses during reset.
  assign busy = rst;
  assign take = start && !busy;

  // transform -> wrap hand-off
  logic                     xf_valid;
  logic signed [XF_W-1:0]    xf_u, xf_v;
  logic signed [COORD_W-1:0] xf_raw_u, xf_raw_v;

  // Four stages: (x - 1/2) * scale, rotation products, sum + translate, tiling.
  txuvw_xform #(
    .FRAC (COORD_FRAC_BITS)
  ) u_xform (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take),
    .u_in      (u_in),
    .v_in      (v_in),
    .cfg       (cfg),
    .out_valid (xf_valid),
    .t_u       (xf_u),
    .t_v       (xf_v),
    .raw_u     (xf_raw_u),
    .raw_v     (xf_raw_v)
  );

  // Seven stages: mode select and 3t, magnitudes, truncation, face number,
  // face magnitude, mod 3 folding, face select into the output register.
  txuvw_wrap #(
    .FRAC (COORD_FRAC_BITS)
  ) u_wrap (
    .clk      (clk),
    .rst      (rst),
    .in_valid (xf_valid),
    .t_u      (xf_u),
    .t_v      (xf_v),
    .raw_u    (xf_raw_u),
    .raw_v    (xf_raw_v),
    .mode     (cfg.wrap_mode),
    .done     (done),
    .u_out    (u_out),
    .v_out    (v_out)
  );

endmodule

// ===== tb/txuvw_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the texture coordinate transform and wrap unit: watches the item,
// result and register write channels, predicts each wrapped pair and compares.
// Depends on txuvw_pkg.
module txuvw_checker
  import txuvw_pkg::*;
#(
  parameter int FRAC = COORD_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic signed [COORD_W-1:0]   u_in,
  input  logic signed [COORD_W-1:0]   v_in,
  input  logic                        done,
  input  logic signed [COORD_W-1:0]   u_out,
  input  logic signed [COORD_W-1:0]   v_out,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  output int                          mismatch_count,
  output int                          pending
);

  localparam longint ONE      = longint'(1) <<< FRAC;
  localparam longint HALF     = ONE >>> 1;
  localparam longint COORD_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -(longint'(1) <<< (COORD_W - 1));

  typedef struct packed {
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
  } coord_pair_t;

  cfg_t        cfg_shadow;
  coord_pair_t wrapped_q[$];
  coord_pair_t want;

  initial begin
    mismatch_count = 0;
    pending = 0;
    cfg_shadow = CFG_RESET;
  end

  // remainder that keeps the sign of x, modulus 2^bits
  function automatic longint rem_frac(input longint x, input int bits);
    longint m;
    m = (longint'(1) <<< bits) - 1;
    return (x >= 0) ? (x & m) : -((-x) & m);
  endfunction

  function automatic longint trunc_whole(input longint x);
    return (x >= 0) ? (x >>> FRAC) : -((-x) >>> FRAC);
  endfunction

  function automatic logic [COORD_W-1:0] sat_coord(input longint x);
    longint y;
    y = (x > COORD_HI) ? COORD_HI : ((x < COORD_LO) ? COORD_LO : x);
    return y[COORD_W-1:0];
  endfunction

  function automatic coord_pair_t transform_wrap(input logic signed [COORD_W-1:0] u_raw,
                                                 input logic signed [COORD_W-1:0] v_raw,
                                                 input cfg_t r);
    longint ui, vi, sc_u, sc_v, cs, sn, of_u, of_v, tl_u, tl_v;
    longint u, v, nu, nv, ru, rv, su, sv, face, lu, lv;
    ui = u_raw;
    vi = v_raw;
    sc_u = $signed(r.scale_u);
    sc_v = $signed(r.scale_v);
    cs = $signed(r.rot_cos);
    sn = $signed(r.rot_sin);
    of_u = $signed(r.offs_u);
    of_v = $signed(r.offs_v);
    tl_u = $signed(r.tile_u);
    tl_v = $signed(r.tile_v);

    u = ((ui - HALF) * sc_u) >>> SCALE_FRAC;
    v = ((vi - HALF) * sc_v) >>> SCALE_FRAC;
    nu = (u * cs - v * sn) >>> ROT_FRAC;
    nv = (u * sn + v * cs) >>> ROT_FRAC;
    u = ((nu + HALF + of_u) * tl_u) >>> SCALE_FRAC;
    v = ((nv + HALF + of_v) * tl_v) >>> SCALE_FRAC;

    ru = u;
    rv = v;
    case (r.wrap_mode)
      WRAP_REPEAT: begin
        ru = rem_frac(u, FRAC);
        rv = rem_frac(v, FRAC);
        if (ru < 0) ru += ONE;
        if (rv < 0) rv += ONE;
      end
      WRAP_MIRROR: begin
        ru = rem_frac(u, FRAC + 1);
        rv = rem_frac(v, FRAC + 1);
        if (ru < 0) ru += 2 * ONE;
        if (rv < 0) rv += 2 * ONE;
        if (ru > ONE) ru = 2 * ONE - ru;
        if (rv > ONE) rv = 2 * ONE - rv;
      end
      WRAP_CLAMP: begin
        ru = (u < 0) ? 0 : ((u > ONE) ? ONE : u);
        rv = (v < 0) ? 0 : ((v > ONE) ? ONE : v);
      end
      WRAP_PLANAR: begin
        ru = ui;
        rv = vi;
      end
      WRAP_CUBIC: begin
        su = 3 * u;
        sv = 3 * v;
        face = trunc_whole(su) + 3 * trunc_whole(sv);
        lu = rem_frac(su, FRAC);
        lv = rem_frac(sv, FRAC);
        // a negative face that is not a multiple of 6 leaves the transformed pair untouched
        case (face % 6)
          0: begin ru = lu;       rv = lv;       end
          1: begin ru = lv;       rv = ONE - lu; end
          2: begin ru = ONE - lu; rv = lv;       end
          3: begin ru = ONE - lv; rv = ONE - lu; end
          4: begin ru = lu;       rv = ONE - lv; end
          5: begin ru = lu;       rv = lv;       end
          default: ;
        endcase
      end
      default: ;  // undefined modes pass the transformed pair
    endcase
    return '{u: sat_coord(ru), v: sat_coord(rv)};
  endfunction

  task automatic note_failure(input string msg);
    if (mismatch_count < 10) $display("%0t MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_shadow = CFG_RESET;
      wrapped_q.delete();
    end else begin
      if (done) begin
        if (wrapped_q.size() == 0) begin
          note_failure($sformatf("unexpected result u=%0d v=%0d", u_out, v_out));
        end else begin
          want = wrapped_q.pop_front();
          if (u_out !== want.u)
            note_failure($sformatf("u_out expected %0d actual %0d", $signed(want.u), u_out));
          if (v_out !== want.v)
            note_failure($sformatf("v_out expected %0d actual %0d", $signed(want.v), v_out));
        end
      end
      if (start && !busy) wrapped_q.push_back(transform_wrap(u_in, v_in, cfg_shadow));
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE:       {cfg_shadow.scale_u, cfg_shadow.scale_v} = cfg_wdata[31:0];
          REG_ROTATION:    {cfg_shadow.rot_cos, cfg_shadow.rot_sin} = cfg_wdata[31:0];
          REG_TRANSLATION: {cfg_shadow.offs_u, cfg_shadow.offs_v} = cfg_wdata[47:0];
          REG_TILING:      {cfg_shadow.tile_u, cfg_shadow.tile_v} = cfg_wdata[31:0];
          REG_WRAP_MODE:   cfg_shadow.wrap_mode = cfg_wdata[MODE_W-1:0];
          default: ;
        endcase
      end
    end
    pending = wrapped_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the texture coordinate transform and wrap testbench: clock, reset, item
// and register stimulus, watchdog and verdict. Depends on txuvw_pkg, txuvw_checker
// and texture_uv_transform_wrap_top.
module tb;
  import txuvw_pkg::*;

  localparam longint ONE         = longint'(1) <<< COORD_FRAC_BITS_DEF;
  localparam int     SETTINGS_N  = 16;   // register settings in the random part
  localparam int     ITEMS_EACH  = 49;   // items sent per setting
  localparam int     SETTLE      = 16;   // wait after draining, before a register write
  localparam int     STALL_LIMIT = 2000; // cycles with no traffic before giving up
  localparam logic [COORD_W-1:0] C_MAX = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] C_MIN = 24'h800000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] u_in = '0;
  logic signed [COORD_W-1:0] v_in = '0;
  logic done;
  logic signed [COORD_W-1:0] u_out;
  logic signed [COORD_W-1:0] v_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int wrapped_pending;
  int idle_pct = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  texture_uv_transform_wrap_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .u_in      (u_in),
    .v_in      (v_in),
    .done      (done),
    .u_out     (u_out),
    .v_out     (v_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  txuvw_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .u_in           (u_in),
    .v_in           (v_in),
    .done           (done),
    .u_out          (u_out),
    .v_out          (v_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending        (wrapped_pending)
  );

  // Watchdog: any accepted item, result or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One item. start is left high on return so back-to-back items never drop it;
  // busy is read at the falling edge, so it is the value the next rising edge sees.
  task automatic send_item(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    bit stalled;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    u_in  <= u;
    v_in  <= v;
    do begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end while (stalled);
  endtask

  // Sender pauses until every predicted pair has come back, then lets the
  // pipeline settle so a register write cannot touch an item in flight.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (wrapped_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes every register; unused upper data bits carry noise, and now and then
  // an unmapped index is written too, which must change nothing.
  task automatic load_config(input cfg_t c);
    logic [63:0] fill;
    fill = {$urandom, $urandom};
    put_reg(REG_SCALE,       {fill[47:32], c.scale_u, c.scale_v});
    put_reg(REG_ROTATION,    {fill[31:16], c.rot_cos, c.rot_sin});
    put_reg(REG_TRANSLATION, {c.offs_u, c.offs_v});
    put_reg(REG_TILING,      {fill[63:48], c.tile_u, c.tile_v});
    put_reg(REG_WRAP_MODE,   {fill[CFG_DATA_W-1:MODE_W], c.wrap_mode});
    if ($urandom_range(1) == 1) put_reg(3'($urandom_range(7, 5)), fill[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  // Q8.8 factor: small magnitudes half the time, otherwise unity, extremes or raw bits.
  function automatic logic [PAIR_W-1:0] rand_q88();
    int t;
    t = $urandom_range(2048);
    case ($urandom_range(5))
      0:       return 16'h0100;
      1:       return 16'($urandom);
      2:       return ($urandom_range(1) == 1) ? 16'h7FFF : 16'h8000;
      default: return 16'(t - 1024);
    endcase
  endfunction

  function automatic cfg_t rand_setting(input int k);
    cfg_t c;
    int t;
    c = CFG_RESET;
    if (k == 1) begin
      c = '{scale_u: 16'h7FFF, scale_v: 16'h7FFF, rot_cos: 16'h7FFF, rot_sin: 16'h7FFF,
            offs_u: 24'h7FFFFF, offs_v: 24'h7FFFFF, tile_u: 16'h7FFF, tile_v: 16'h7FFF,
            wrap_mode: WRAP_REPEAT};
    end else if (k == 2) begin
      c = '{scale_u: 16'h8000, scale_v: 16'h8000, rot_cos: 16'h8000, rot_sin: 16'h8000,
            offs_u: 24'h800000, offs_v: 24'h800000, tile_u: 16'h8000, tile_v: 16'h8000,
            wrap_mode: WRAP_REPEAT};
    end else if (k != 0) begin
      c.scale_u = rand_q88();
      c.scale_v = rand_q88();
      c.tile_u  = rand_q88();
      c.tile_v  = rand_q88();
      t = $urandom_range(32768);
      case ($urandom_range(3))
        0: {c.rot_cos, c.rot_sin} = {16'h4000, 16'h0000};  // no turn
        1: {c.rot_cos, c.rot_sin} = {16'h0000, 16'h4000};  // quarter turn
        2: {c.rot_cos, c.rot_sin} = $urandom;
        default: {c.rot_cos, c.rot_sin} = {16'(t - 16384), 16'($urandom_range(32768) - 16384)};
      endcase
      t = $urandom_range(32'(4 * ONE));
      case ($urandom_range(2))
        0:       {c.offs_u, c.offs_v} = '0;
        1:       {c.offs_u, c.offs_v} = {24'($urandom), 24'($urandom)};
        default: {c.offs_u, c.offs_v} = {24'(t - 2 * ONE),
                                         24'(int'($urandom_range(32'(4 * ONE))) - 2 * ONE)};
      endcase
    end
    c.wrap_mode = 3'(k);  // walks every encoding, undefined ones too
    return c;
  endfunction

  // Coordinate mix: raw bits, values hugging whole numbers (wrap edges), values
  // near thirds (cube face edges), and the bulk spread over +-4.0.
  function automatic logic [COORD_W-1:0] rand_coord();
    longint k, x;
    int d;
    k = $urandom_range(24);
    d = $urandom_range(4);
    case ($urandom_range(9))
      0, 1:    x = longint'($urandom);
      2, 3:    x = (k % 9 - 4) * ONE + d - 2;
      4:       x = (k - 12) * ONE / 3 + d - 2;
      default: x = longint'($urandom_range(32'(8 * ONE))) - 4 * ONE;
    endcase
    return x[COORD_W-1:0];
  endfunction

  initial begin
    cfg_t c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: every wrap encoding, coordinate extremes, negative cube faces,
    // negative repeat remainders, mirror folding above one.
    for (int m = 0; m < 8; m++) begin
      if (m != 0) begin
        drain();
        c = CFG_RESET;
        c.wrap_mode = 3'(m);
        load_config(c);
      end
      send_item(24'h000000, C_MAX);
      send_item(C_MIN, 24'(ONE));
      send_item(24'(-(ONE + ONE / 4)), 24'(ONE + ONE / 2 + ONE / 8));
    end

    // Random: sender idles lightly, then heavily, then never.
    for (int k = 0; k < SETTINGS_N; k++) begin
      idle_pct = (k < 6) ? 11 : ((k < 11) ? 62 : 0);
      drain();
      load_config(rand_setting(k));
      repeat (ITEMS_EACH) send_item(rand_coord(), rand_coord());
    end

    drain();
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
